@@ hdl/tsd_pkg.sv @@
// Shared types and constants of the triangle midpoint subdivider.
package tsd_pkg;

    localparam int TEX_WIDTH = 16;

    localparam logic [1:0] SEL_V0  = 2'd0;
    localparam logic [1:0] SEL_V1  = 2'd1;
    localparam logic [1:0] SEL_V2  = 2'd2;
    localparam logic [1:0] SEL_MID = 2'd3;

    localparam logic [1:0] PAIR_01 = 2'd0;
    localparam logic [1:0] PAIR_12 = 2'd1;
    localparam logic [1:0] PAIR_02 = 2'd2;

    localparam logic DIR_NRM = 1'b0;
    localparam logic DIR_TAN = 1'b1;

    typedef struct packed {
        logic       wr_en;
        logic [1:0] wr_slot;
        logic       out_load;
        logic [1:0] out_sel;
        logic       out_last;
        logic [1:0] pair;
        logic       unit_start;
        logic       dir_sel;
        logic       lat_nrm;
        logic       lat_tan;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic unit_done;
    } t_sts;

endpackage

@@ hdl/tsd_unit.sv @@
// Iterative unit-length rescaler for a three-component direction sum.
module tsd_unit
    import tsd_pkg::*;
#(
    parameter int DW = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [DW:0]   i_sum [3],
    output logic                 o_done,
    output logic [DW-1:0]        o_res [3]
);

    localparam int MW = DW + 1;
    localparam int QW = 2 * DW + 4;
    localparam int LW = DW + 2;
    localparam int NW = 2 * DW + 1;
    localparam int RW = DW + 4;
    localparam int CW = $clog2(DW);
    localparam logic [CW-1:0] CNT_LAST = CW'(DW - 1);
    localparam logic [DW-1:0] TOP = {1'b0, {(DW - 1){1'b1}}};

    localparam logic [2:0] U_IDLE = 3'd0;
    localparam logic [2:0] U_NORM = 3'd1;
    localparam logic [2:0] U_SQ   = 3'd2;
    localparam logic [2:0] U_SQRT = 3'd3;
    localparam logic [2:0] U_DIVI = 3'd4;
    localparam logic [2:0] U_DIV  = 3'd5;
    localparam logic [2:0] U_FIN  = 3'd6;

    logic [2:0]      r_state;
    logic [MW-1:0]   r_mag [3];
    logic [2:0]      r_neg;
    logic [2*MW-1:0] r_prod;
    logic [QW-1:0]   r_q;
    logic [QW-1:0]   r_root;
    logic [QW-1:0]   r_bit;
    logic [LW-1:0]   r_len;
    logic [RW-1:0]   r_rem;
    logic [DW-1:0]   r_num;
    logic [DW-1:0]   r_quo;
    logic [CW-1:0]   r_cnt;
    logic [1:0]      r_j;
    logic [DW-1:0]   r_res [3];

    logic [MW-1:0]   n_mag [3];
    logic [QW-1:0]   n_try;
    logic [NW-1:0]   n_num;
    logic [RW-1:0]   n_rem2;
    logic [RW-1:0]   n_dn;
    logic            n_qbit;
    logic [DW-1:0]   n_quo;
    logic [DW-1:0]   n_v;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_mag[i] = i_sum[i][DW] ? MW'(~i_sum[i] + 1'b1) : MW'(i_sum[i]);
        end
        n_try  = r_root + r_bit;
        n_num  = NW'({r_mag[r_j], {(DW - 1){1'b0}}}) + NW'(r_len);
        n_rem2 = {r_rem[RW-2:0], r_num[DW-1]};
        n_dn   = RW'({r_len, 1'b0});
        n_qbit = (n_rem2 >= n_dn);
        n_quo  = {r_quo[DW-2:0], n_qbit};
        n_v    = n_quo[DW-1] ? TOP : n_quo;
    end

    assign o_done = (r_state == U_FIN);
    assign o_res  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
        end else begin
            case (r_state)
                U_IDLE: begin
                    if (i_start) begin
                        r_mag <= n_mag;
                        r_neg <= {i_sum[2][DW], i_sum[1][DW], i_sum[0][DW]};
                        if ((n_mag[0] | n_mag[1] | n_mag[2]) == '0) begin
                            for (int i = 0; i < 3; i++) r_res[i] <= '0;
                            r_state <= U_FIN;
                        end else begin
                            r_state <= U_NORM;
                        end
                    end
                end
                U_NORM: begin
                    if (r_mag[0][DW] | r_mag[1][DW] | r_mag[2][DW]) begin
                        r_j     <= 2'd0;
                        r_q     <= '0;
                        r_state <= U_SQ;
                    end else begin
                        for (int i = 0; i < 3; i++) r_mag[i] <= {r_mag[i][MW-2:0], 1'b0};
                    end
                end
                U_SQ: begin
                    if (r_j != 2'd3) begin
                        r_prod <= r_mag[r_j] * r_mag[r_j];
                    end
                    if (r_j != 2'd0) begin
                        r_q <= r_q + QW'(r_prod);
                    end
                    if (r_j == 2'd3) begin
                        r_root  <= '0;
                        r_bit   <= QW'(1) << (QW - 2);
                        r_state <= U_SQRT;
                    end
                    r_j <= r_j + 2'd1;
                end
                U_SQRT: begin
                    if (r_bit == '0) begin
                        r_len   <= r_root[LW-1:0];
                        r_j     <= 2'd0;
                        r_state <= U_DIVI;
                    end else begin
                        if (r_q >= n_try) begin
                            r_q    <= r_q - n_try;
                            r_root <= (r_root >> 1) + r_bit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                U_DIVI: begin
                    r_rem   <= RW'(n_num[NW-1:DW]);
                    r_num   <= n_num[DW-1:0];
                    r_quo   <= '0;
                    r_cnt   <= '0;
                    r_state <= U_DIV;
                end
                U_DIV: begin
                    r_rem <= n_qbit ? (n_rem2 - n_dn) : n_rem2;
                    r_num <= {r_num[DW-2:0], 1'b0};
                    r_quo <= n_quo;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_LAST) begin
                        r_res[r_j] <= r_neg[r_j] ? (~n_v + 1'b1) : n_v;
                        if (r_j == 2'd2) begin
                            r_state <= U_FIN;
                        end else begin
                            r_j     <= r_j + 2'd1;
                            r_state <= U_DIVI;
                        end
                    end
                end
                U_FIN: begin
                    r_state <= U_IDLE;
                end
                default: begin
                    r_state <= U_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hdl/tsd_datapath.sv @@
// Datapath: held corners, midpoint arithmetic and the output register.
module tsd_datapath
    import tsd_pkg::*;
#(
    parameter int PW = 32,
    parameter int DW = 16,
    parameter int BW = 224
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    output t_sts          o_sts,
    input  logic [BW-1:0] i_tdata,
    input  logic          i_m_tready,
    output logic          o_m_tvalid,
    output logic [BW-1:0] o_m_tdata,
    output logic          o_m_tlast
);

    localparam int DOFF = 3 * PW;
    localparam int TOFF = 3 * PW + 6 * DW;
    localparam int VW   = TOFF + 2 * TEX_WIDTH;

    logic [VW-1:0] r_v0;
    logic [VW-1:0] r_v1;
    logic [VW-1:0] r_v2;
    logic [DW-1:0] r_nrm [3];
    logic [DW-1:0] r_tan [3];
    logic          r_out_valid;
    logic [VW-1:0] r_out_data;
    logic          r_out_last;

    logic [VW-1:0]         n_a;
    logic [VW-1:0]         n_b;
    logic [VW-1:0]         n_mid;
    logic [VW-1:0]         n_out;
    logic signed [DW:0]    n_sum [3];
    logic [PW:0]           n_psum;
    logic [TEX_WIDTH:0]    n_tsum;
    logic                  n_done;
    logic [DW-1:0]         n_res [3];
    int                    n_off;

    tsd_unit #(.DW(DW)) u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.unit_start),
        .i_sum   (n_sum),
        .o_done  (n_done),
        .o_res   (n_res)
    );

    always_comb begin
        case (i_cmd.pair)
            PAIR_01: begin
                n_a = r_v0;
                n_b = r_v1;
            end
            PAIR_12: begin
                n_a = r_v1;
                n_b = r_v2;
            end
            default: begin
                n_a = r_v0;
                n_b = r_v2;
            end
        endcase

        n_off = (i_cmd.dir_sel == DIR_NRM) ? DOFF : DOFF + 3 * DW;
        for (int i = 0; i < 3; i++) begin
            n_sum[i] = signed'({n_a[n_off + i * DW + DW - 1], n_a[n_off + i * DW +: DW]})
                     + signed'({n_b[n_off + i * DW + DW - 1], n_b[n_off + i * DW +: DW]});
        end

        n_mid = '0;
        n_psum = '0;
        n_tsum = '0;
        for (int i = 0; i < 3; i++) begin
            n_psum = {n_a[i * PW + PW - 1], n_a[i * PW +: PW]}
                   + {n_b[i * PW + PW - 1], n_b[i * PW +: PW]};
            n_mid[i * PW +: PW] = n_psum[PW:1];
            n_mid[DOFF + i * DW +: DW] = r_nrm[i];
            n_mid[DOFF + (3 + i) * DW +: DW] = r_tan[i];
        end
        for (int i = 0; i < 2; i++) begin
            n_tsum = {1'b0, n_a[TOFF + i * TEX_WIDTH +: TEX_WIDTH]}
                   + {1'b0, n_b[TOFF + i * TEX_WIDTH +: TEX_WIDTH]};
            n_mid[TOFF + i * TEX_WIDTH +: TEX_WIDTH] = n_tsum[TEX_WIDTH:1];
        end

        case (i_cmd.out_sel)
            SEL_V0:  n_out = r_v0;
            SEL_V1:  n_out = r_v1;
            SEL_V2:  n_out = r_v2;
            default: n_out = n_mid;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            case (i_cmd.wr_slot)
                2'd0:    r_v0 <= i_tdata[VW-1:0];
                2'd1:    r_v1 <= i_tdata[VW-1:0];
                default: r_v2 <= i_tdata[VW-1:0];
            endcase
        end
        if (n_done && i_cmd.lat_nrm) r_nrm <= n_res;
        if (n_done && i_cmd.lat_tan) r_tan <= n_res;
        if (i_cmd.out_load) begin
            r_out_data <= n_out;
            r_out_last <= i_cmd.out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.out_free  = !r_out_valid || i_m_tready;
    assign o_sts.unit_done = n_done;
    assign o_m_tvalid      = r_out_valid;
    assign o_m_tdata       = BW'(r_out_data);
    assign o_m_tlast       = r_out_last;

endmodule

@@ hdl/tsd_ctrl.sv @@
// Controller: corner counting and sequencing of the six output beats.
module tsd_ctrl
    import tsd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_NRM  = 3'd2;
    localparam logic [2:0] S_TAN  = 3'd3;
    localparam logic [2:0] S_MID  = 3'd4;
    localparam logic [2:0] S_TST  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [1:0] r_slot;
    logic [1:0] n_slot;
    logic [2:0] r_idx;
    logic [2:0] n_idx;

    always_comb begin
        n_state = r_state;
        n_slot  = r_slot;
        n_idx   = r_idx;
        o_cmd   = '0;
        o_s_tready = 1'b0;
        case (r_idx)
            3'd3:    o_cmd.pair = PAIR_01;
            3'd4:    o_cmd.pair = PAIR_12;
            default: o_cmd.pair = PAIR_02;
        endcase
        o_cmd.out_sel = SEL_MID;
        o_cmd.dir_sel = DIR_NRM;

        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.wr_en = 1'b1;
                    if (r_slot >= 2'd2) begin
                        o_cmd.wr_slot = 2'd2;
                        n_slot  = 2'd0;
                        n_idx   = 3'd0;
                        n_state = S_LOAD;
                    end else begin
                        o_cmd.wr_slot = r_slot;
                        n_slot = r_slot + 2'd1;
                    end
                end
            end
            S_LOAD: begin
                if (r_idx < 3'd3) begin
                    if (i_sts.out_free) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_sel  = r_idx[1:0];
                        n_idx = r_idx + 3'd1;
                    end
                end else begin
                    o_cmd.unit_start = 1'b1;
                    n_state = S_NRM;
                end
            end
            S_NRM: begin
                if (i_sts.unit_done) begin
                    o_cmd.lat_nrm = 1'b1;
                    n_state = S_TST;
                end
            end
            S_TST: begin
                o_cmd.unit_start = 1'b1;
                o_cmd.dir_sel    = DIR_TAN;
                n_state = S_TAN;
            end
            S_TAN: begin
                o_cmd.dir_sel = DIR_TAN;
                if (i_sts.unit_done) begin
                    o_cmd.lat_tan = 1'b1;
                    n_state = S_MID;
                end
            end
            S_MID: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = (r_idx == 3'd5);
                    if (r_idx == 3'd5) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 3'd1;
                        n_state = S_LOAD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slot  <= 2'd0;
            r_idx   <= 3'd0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            r_idx   <= n_idx;
        end
    end

endmodule

@@ hdl/triangle_midpoint_subdivider.sv @@
// Top level of the one-to-four midpoint triangle subdivider.
//
//  channel  dir  beat                          sideband
//  s_axis   in   one vertex                    -
//  m_axis   out  one emitted vertex (6/tri)    tlast on sixth vertex
//
// First and second corners are each stored as they are accepted. The third corner
// starts the output sequence, whose pace is set by the shared normalize unit (shift
// search of k <= DIR_WIDTH steps, 3 squares, bit-serial sqrt, 3 serial divides) run
// once per normal and tangent midpoint; a zero sum skips straight to the finish
// state instead. Corners pass out first.
// Synchronous active-low reset clears the corner count and output valid.
// Output stalls hold the sequence; input is taken only between triangles.
module triangle_midpoint_subdivider
    import tsd_pkg::*;
#(
    parameter int POS_WIDTH = 32,
    parameter int DIR_WIDTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, tan_x, tan_y, tan_z, tex_u, tex_v
    input  logic [((3 * POS_WIDTH + 6 * DIR_WIDTH + 2 * TEX_WIDTH + 7) / 8) * 8 - 1:0]
                                 i_s_axis_tdata,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // out_pos_x..z, out_nrm_x..z, out_tan_x..z, out_tex_u, out_tex_v
    output logic [((3 * POS_WIDTH + 6 * DIR_WIDTH + 2 * TEX_WIDTH + 7) / 8) * 8 - 1:0]
                                 o_m_axis_tdata,
    output logic                 o_m_axis_tlast
);

    localparam int BW = ((3 * POS_WIDTH + 6 * DIR_WIDTH + 2 * TEX_WIDTH + 7) / 8) * 8;

    t_cmd w_cmd;
    t_sts w_sts;

    tsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tsd_datapath #(
        .PW (POS_WIDTH),
        .DW (DIR_WIDTH),
        .BW (BW)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_tdata    (i_s_axis_tdata),
        .i_m_tready (i_m_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tlast  (o_m_axis_tlast)
    );

endmodule
